FILE: hdl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types, byte codes and helpers for the CBOR block message parser:
// parse phases, key codes, the classified byte word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package cbp_pkg;

   // Longest key text accepted is KEY_BUFFER_BYTES - 1 bytes
   localparam int KEY_BUFFER_BYTES = 8;
   localparam int KEY_LEN_W        = $clog2(KEY_BUFFER_BYTES);

   // Front queue between classifier and parser
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   // Result queue
   localparam int RQ_DEPTH = 2;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // CBOR head bytes
   localparam logic [7:0] MAP_INDEF    = 8'hBF;
   localparam logic [7:0] BREAK_CODE   = 8'hFF;
   localparam logic [7:0] MAP_DEF_LO   = 8'hA0;
   localparam logic [7:0] MAP_DEF_HI   = 8'hB7;
   localparam logic [7:0] TEXT_LO      = 8'h60;
   localparam logic [7:0] TEXT_HI      = 8'h77;
   localparam logic [7:0] UINT_IMM_MAX = 8'h17;
   localparam logic [7:0] UINT_1B      = 8'h18;
   localparam logic [7:0] UINT_2B      = 8'h19;
   localparam logic [7:0] UINT_4B      = 8'h1A;
   localparam logic [7:0] BSTR_LO      = 8'h40;
   localparam logic [7:0] BSTR_HI      = 8'h57;
   localparam logic [7:0] BSTR_1B      = 8'h58;
   localparam logic [7:0] BSTR_2B      = 8'h59;

   // Single-letter key characters
   localparam logic [7:0] CHAR_C = 8'h63;
   localparam logic [7:0] CHAR_I = 8'h69;
   localparam logic [7:0] CHAR_L = 8'h6C;
   localparam logic [7:0] CHAR_B = 8'h62;

   typedef enum logic [3:0] {
      PH_MAP_HEAD,
      PH_KEY_HEAD,
      PH_KEY_TEXT,
      PH_UINT_HEAD,
      PH_UINT_BYTES,
      PH_BSTR_HEAD,
      PH_BSTR_LEN,
      PH_BSTR_DATA,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef enum logic [2:0] {
      KEY_NONE,
      KEY_C,
      KEY_I,
      KEY_L,
      KEY_B,
      KEY_OTHER,
      KEY_PENDING
   } key_type;

   // One input byte with its decode flags
   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      logic                 map_indef;
      logic                 map_def;
      logic                 brk;
      logic                 key_ok;
      logic [KEY_LEN_W-1:0] key_len;
      key_type              key_char;
      logic                 uint_imm;
      logic                 uint_ext;
      logic [2:0]           uint_nbytes;
      logic                 bstr_imm;
      logic                 bstr_ext;
      logic                 bstr_two;
   } class_type;

   // One result item
   typedef struct packed {
      logic               payload_valid;
      logic [7:0]         payload_byte;
      logic               done_res;
      logic               accepted;
      logic signed [31:0] block_num;
      logic signed [31:0] file_num;
      logic [15:0]        payload_count;
   } rsp_type;

   // Phase that follows a completed key
   function automatic phase_type phase_after_key(input key_type k);
      phase_type p;
      p = PH_FAIL;
      unique case (k)
         KEY_B:                    p = PH_BSTR_HEAD;
         KEY_C, KEY_I, KEY_L:      p = PH_UINT_HEAD;
         default:                  p = PH_FAIL;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cbp_front.sv
// ----------------------------------------------------------------------------
// cbp_front
// Accepts message bytes, decodes the CBOR head classes of each byte and
// holds the decoded words in a short queue for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last,
   input  wire logic              push,
   output logic                   full,
   input  wire logic              item_pop,
   output logic                   item_valid,
   output cbp_pkg::class_type     item
);
   import cbp_pkg::*;

   class_type             cls;
   class_type             store_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   // Decode the byte classes
   always_comb begin
      cls             = '0;
      cls.data        = req_data_byte;
      cls.last        = req_last;
      cls.map_indef   = (req_data_byte == MAP_INDEF);
      cls.map_def     = (req_data_byte >= MAP_DEF_LO) && (req_data_byte <= MAP_DEF_HI);
      cls.brk         = (req_data_byte == BREAK_CODE);
      cls.key_ok      = (req_data_byte >= TEXT_LO) && (req_data_byte <= TEXT_HI) &&
                        (req_data_byte[4:0] < 5'(KEY_BUFFER_BYTES));
      cls.key_len     = KEY_LEN_W'(req_data_byte[4:0]);
      priority if (req_data_byte == CHAR_C) cls.key_char = KEY_C;
      else if (req_data_byte == CHAR_I)     cls.key_char = KEY_I;
      else if (req_data_byte == CHAR_L)     cls.key_char = KEY_L;
      else if (req_data_byte == CHAR_B)     cls.key_char = KEY_B;
      else                                  cls.key_char = KEY_OTHER;
      cls.uint_imm    = (req_data_byte <= UINT_IMM_MAX);
      cls.uint_ext    = (req_data_byte >= UINT_1B) && (req_data_byte <= UINT_4B);
      priority if (req_data_byte == UINT_1B) cls.uint_nbytes = 3'd1;
      else if (req_data_byte == UINT_2B)     cls.uint_nbytes = 3'd2;
      else                                   cls.uint_nbytes = 3'd4;
      cls.bstr_imm    = (req_data_byte >= BSTR_LO) && (req_data_byte <= BSTR_HI);
      cls.bstr_ext    = (req_data_byte == BSTR_1B) || (req_data_byte == BSTR_2B);
      cls.bstr_two    = (req_data_byte == BSTR_2B);
   end

   // Queue control
   always_comb begin
      full       = (cnt_ff == FQ_CNT_W'(FQ_DEPTH));
      item_valid = (cnt_ff != '0);
      do_push    = push && !full;
      do_pop     = item_pop && item_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + FQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop  ? rd_ptr_ff + FQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in     = cnt_ff + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
      item       = store_ff[rd_ptr_ff];
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the decoded beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cbp_back.sv
// ----------------------------------------------------------------------------
// cbp_back
// Parser state machine: walks the map, keys and values one decoded byte per
// cycle unless rq_full, streams payload bytes, forms the last byte's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire cbp_pkg::class_type item,
   output logic                    item_pop,
   input  wire logic               rq_full,
   output logic                    rq_push,
   output cbp_pkg::rsp_type        rq_data
);
   import cbp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  indef_ff, indef_in;
   logic [4:0]            pairs_ff, pairs_in;
   key_type               key_ff, key_in;
   logic [KEY_LEN_W-1:0]  klen_ff, klen_in;
   logic [31:0]           acc_ff, acc_in;
   logic [15:0]           left_ff, left_in;
   logic [31:0]           block_ff, block_in;
   logic [31:0]           file_ff, file_in;
   logic [15:0]           plen_ff, plen_in;
   logic                  seen_ff, seen_in;

   logic                  go;
   logic [4:0]            pairs_dec;
   phase_type             ep_phase;
   logic [4:0]            ep_pairs;
   key_type               kc;
   logic [15:0]           n_len;
   logic                  pv;
   logic                  verdict;

   assign go       = item_valid && !rq_full;
   assign item_pop = go;

   // End-of-pair step
   always_comb begin
      pairs_dec = pairs_ff - 5'd1;
      if (indef_ff) begin
         ep_phase = PH_KEY_HEAD;
         ep_pairs = pairs_ff;
      end else begin
         ep_phase = (pairs_dec == 5'd0) ? PH_DONE : PH_KEY_HEAD;
         ep_pairs = pairs_dec;
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      indef_in = indef_ff;
      pairs_in = pairs_ff;
      key_in   = key_ff;
      klen_in  = klen_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      block_in = block_ff;
      file_in  = file_ff;
      plen_in  = plen_ff;
      seen_in  = seen_ff;
      kc       = key_ff;
      n_len    = '0;
      unique case (phase_ff)
         PH_MAP_HEAD: begin
            if (item.map_indef) begin
               indef_in = 1'b1;
               phase_in = PH_KEY_HEAD;
            end else if (item.map_def) begin
               pairs_in = item.data[4:0];
               phase_in = (item.data[4:0] == 5'd0) ? PH_DONE : PH_KEY_HEAD;
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_KEY_HEAD: begin
            if (indef_ff && item.brk) begin
               phase_in = PH_DONE;
            end else if (item.key_ok) begin
               klen_in = item.key_len;
               if (item.key_len == '0) begin
                  key_in   = KEY_OTHER;
                  phase_in = PH_FAIL;
               end else begin
                  key_in   = (item.key_len == KEY_LEN_W'(1)) ? KEY_PENDING : KEY_OTHER;
                  phase_in = PH_KEY_TEXT;
               end
            end else begin
               phase_in = indef_ff ? PH_DONE : PH_FAIL;
            end
         end
         PH_KEY_TEXT: begin
            kc      = (key_ff == KEY_PENDING) ? item.key_char : key_ff;
            key_in  = kc;
            klen_in = klen_ff - KEY_LEN_W'(1);
            if (klen_in == '0) begin
               phase_in = phase_after_key(kc);
            end
         end
         PH_UINT_HEAD: begin
            acc_in = '0;
            if (item.uint_imm) begin
               if (key_ff == KEY_C) block_in = {24'd0, item.data};
               else if (key_ff == KEY_I) file_in = {24'd0, item.data};
               phase_in = ep_phase;
               pairs_in = ep_pairs;
            end else if (item.uint_ext) begin
               left_in  = {13'd0, item.uint_nbytes};
               phase_in = PH_UINT_BYTES;
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_UINT_BYTES: begin
            acc_in  = {acc_ff[23:0], item.data};
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               if (key_ff == KEY_C) block_in = acc_in;
               else if (key_ff == KEY_I) file_in = acc_in;
               phase_in = ep_phase;
               pairs_in = ep_pairs;
            end
         end
         PH_BSTR_HEAD: begin
            acc_in = '0;
            if (item.bstr_imm) begin
               n_len   = {11'd0, item.data[4:0]};
               plen_in = n_len;
               seen_in = 1'b1;
               if (n_len == 16'd0) begin
                  phase_in = ep_phase;
                  pairs_in = ep_pairs;
               end else begin
                  left_in  = n_len;
                  phase_in = PH_BSTR_DATA;
               end
            end else if (item.bstr_ext) begin
               left_in  = item.bstr_two ? 16'd2 : 16'd1;
               phase_in = PH_BSTR_LEN;
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_BSTR_LEN: begin
            acc_in  = {16'd0, acc_ff[7:0], item.data};
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               n_len   = acc_in[15:0];
               plen_in = n_len;
               seen_in = 1'b1;
               if (n_len == 16'd0) begin
                  phase_in = ep_phase;
                  pairs_in = ep_pairs;
               end else begin
                  left_in  = n_len;
                  phase_in = PH_BSTR_DATA;
               end
            end
         end
         PH_BSTR_DATA: begin
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               phase_in = ep_phase;
               pairs_in = ep_pairs;
            end
         end
         PH_DONE, PH_FAIL: begin
         end
         default: begin
         end
      endcase
   end

   // Result word
   always_comb begin
      pv      = (phase_ff == PH_BSTR_DATA);
      verdict = 1'b0;
      if (item.last) begin
         if (phase_in == PH_DONE) begin
            verdict = indef_in ? seen_in : (seen_in && !block_in[31]);
         end else if (indef_in && (phase_in == PH_KEY_HEAD || phase_in == PH_KEY_TEXT)) begin
            verdict = seen_in;
         end
      end
      rq_push               = go && (pv || item.last);
      rq_data.payload_valid = pv;
      rq_data.payload_byte  = pv ? item.data : 8'd0;
      rq_data.done_res      = item.last;
      rq_data.accepted      = verdict;
      rq_data.block_num     = $signed(block_in);
      rq_data.file_num      = $signed(file_in);
      rq_data.payload_count = plen_in;
   end

   // Hold state; return to reset after the last beat
   always_ff @(posedge clock) begin
      if (reset || (go && item.last)) begin
         phase_ff <= PH_MAP_HEAD;
         indef_ff <= 1'b0;
         pairs_ff <= '0;
         key_ff   <= KEY_NONE;
         klen_ff  <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         block_ff <= '1;
         file_ff  <= '0;
         plen_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in;
         indef_ff <= indef_in;
         pairs_ff <= pairs_in;
         key_ff   <= key_in;
         klen_ff  <= klen_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         block_ff <= block_in;
         file_ff  <= file_in;
         plen_ff  <= plen_in;
         seen_ff  <= seen_in;
      end
   end

   // A message's last beat returns the parser to the map head
   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (go && item.last) |=> (phase_ff == PH_MAP_HEAD))
      else $error("parser did not restart after last beat");

   // Payload streaming always has bytes outstanding
   a_data_left : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BSTR_DATA) |-> (left_ff != 16'd0))
      else $error("payload phase with no bytes left");

   // At the map head no message state survives
   a_head_clean : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MAP_HEAD) |-> (!seen_ff && !indef_ff && (block_ff == '1)))
      else $error("stale state at map head");

endmodule

`default_nettype wire

FILE: hdl/cbp_rsp_queue.sv
// ----------------------------------------------------------------------------
// cbp_rsp_queue
// Result queue: holds finished result words until the receiver pops them,
// so the parser keeps running while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rq_push,
   input  wire cbp_pkg::rsp_type  rq_data,
   output logic                   rq_full,
   output logic                   empty,
   input  wire logic              pop,
   output cbp_pkg::rsp_type       rsp_data
);
   import cbp_pkg::*;

   rsp_type               store_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   // Queue control
   always_comb begin
      rq_full   = (cnt_ff == RQ_CNT_W'(RQ_DEPTH));
      empty     = (cnt_ff == '0);
      do_push   = rq_push && !rq_full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + RQ_CNT_W'(do_push) - RQ_CNT_W'(do_pop);
      rsp_data  = store_ff[rd_ptr_ff];
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the result beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= rq_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cbor_block_message_parser_core.sv
// ----------------------------------------------------------------------------
// cbor_block_message_parser_core
// Byte-serial CBOR map parser for block transfer messages.
//
// Input channel: one message byte per beat (req_data_byte, req_last), taken
// when push is high and full is low. req_last marks the final byte.
// Result channel: a result word is offered while empty is low and taken when
// pop is high. A result is produced for every payload byte of the "b" string
// and for the last byte of a message, which also carries the verdict and the
// decoded block number, file number and payload length. Other bytes give no
// result.
// Throughput: one byte per cycle, sustained while the result queue has room;
// the parser state machine takes one decoded byte each cycle, holding while
// the result queue is full. A byte is written into the input queue, parsed
// from its head, and its result is written into the result queue.
// A four-entry queue after the byte classifier and a two-entry result queue
// let either side stall: when pop stays low, the result queue fills, the
// parser holds, and full rises once the input queue is full.
// Reset clears both queues and returns the parser to expect a map head; the
// same parser state is restored after every last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cbor_block_message_parser_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last,
   input  wire logic         push,
   output logic              full,
   output logic              empty,
   input  wire logic         pop,
   output logic              rsp_payload_valid,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_done_res,
   output logic              rsp_accepted,
   output logic signed [31:0] rsp_block_num,
   output logic signed [31:0] rsp_file_num,
   output logic [15:0]       rsp_payload_count
);
   import cbp_pkg::*;

   class_type  item;
   logic       item_valid;
   logic       item_pop;
   logic       rq_full;
   logic       rq_push;
   rsp_type    rq_data;
   rsp_type    rsp_data;

   cbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .push          (push),
      .full          (full),
      .item_pop      (item_pop),
      .item_valid    (item_valid),
      .item          (item)
   );

   cbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rq_full    (rq_full),
      .rq_push    (rq_push),
      .rq_data    (rq_data)
   );

   cbp_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rq_push  (rq_push),
      .rq_data  (rq_data),
      .rq_full  (rq_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // Unpack the result word
   assign rsp_payload_valid = rsp_data.payload_valid;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_done_res      = rsp_data.done_res;
   assign rsp_accepted      = rsp_data.accepted;
   assign rsp_block_num     = rsp_data.block_num;
   assign rsp_file_num      = rsp_data.file_num;
   assign rsp_payload_count = rsp_data.payload_count;

endmodule

`default_nettype wire

FILE: tb/sv/cbor_block_message_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbor_block_message_parser_core_tb
// Self-checking bench for the byte-serial CBOR block message parser. A short
// scripted set of messages (bad map head, definite and indefinite maps, a
// large block number, an empty map) is followed by random messages: mostly
// well-formed maps with random keys and values, plus truncated, corrupted,
// padded and pure-noise messages. A bit-accurate decoder inside the bench
// predicts every payload beat and verdict not pinned in the script; both
// channels stall at random and a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------

module cbor_block_message_parser_core_tb;

   import cbp_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_BYTES = 1060;

   // Ways to encode a head with an argument
   typedef enum int {UF_IMM, UF_ONE, UF_TWO, UF_FOUR, UF_BAD} head_form_type;

   // One scripted byte; want is used only when pinned is set
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
      logic       pinned;
      rsp_type    want;
   } script_row_type;

   localparam rsp_type NO_PIN = '0;

   logic               clock;
   logic               reset = 1'b1;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last = 1'b0;
   logic               push = 1'b0;
   logic               pop = 1'b0;
   logic               full;
   logic               empty;
   logic               rsp_payload_valid;
   logic [7:0]         rsp_payload_byte;
   logic               rsp_done_res;
   logic               rsp_accepted;
   logic signed [31:0] rsp_block_num;
   logic signed [31:0] rsp_file_num;
   logic [15:0]        rsp_payload_count;

   // Decoder state of the bench
   phase_type             parse_phase;
   bit                    indef_map;
   logic [4:0]            pairs_to_go;
   key_type               key_kind;
   logic [KEY_LEN_W-1:0]  key_chars_left;
   logic [31:0]           uint_acc;
   logic [15:0]           count_left;
   logic [31:0]           blk_val;
   logic [31:0]           file_id;
   logic [15:0]           bstr_len;
   bit                    bstr_seen;

   rsp_type     rsp_due_q[$];
   logic [7:0]  msg_bytes[$];
   bit          pin_active = 1'b0;
   rsp_type     pin_word = '0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   script_row_type opening_script [28] = '{
      // bad map head
      {8'hB8, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'd0}},
      // definite map: c = 0, b = one byte -> accepted
      {8'hA2, 1'b0, 1'b0, NO_PIN},
      {8'h61, 1'b0, 1'b0, NO_PIN},
      {8'h63, 1'b0, 1'b0, NO_PIN},
      {8'h00, 1'b0, 1'b0, NO_PIN},
      {8'h61, 1'b0, 1'b0, NO_PIN},
      {8'h62, 1'b0, 1'b0, NO_PIN},
      {8'h41, 1'b0, 1'b0, NO_PIN},
      {8'hAA, 1'b1, 1'b1, {1'b1, 8'hAA, 1'b1, 1'b1, 32'h0, 32'h0, 16'd1}},
      // indefinite map: i = 0x1234, empty b, break -> accepted
      {8'hBF, 1'b0, 1'b0, NO_PIN},
      {8'h61, 1'b0, 1'b0, NO_PIN},
      {8'h69, 1'b0, 1'b0, NO_PIN},
      {8'h19, 1'b0, 1'b0, NO_PIN},
      {8'h12, 1'b0, 1'b0, NO_PIN},
      {8'h34, 1'b0, 1'b0, NO_PIN},
      {8'h61, 1'b0, 1'b0, NO_PIN},
      {8'h62, 1'b0, 1'b0, NO_PIN},
      {8'h40, 1'b0, 1'b0, NO_PIN},
      {8'hFF, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h1234, 16'd0}},
      // definite map: c = 0xFFFFFFFF, no b -> rejected
      {8'hA1, 1'b0, 1'b0, NO_PIN},
      {8'h61, 1'b0, 1'b0, NO_PIN},
      {8'h63, 1'b0, 1'b0, NO_PIN},
      {8'h1A, 1'b0, 1'b0, NO_PIN},
      {8'hFF, 1'b0, 1'b0, NO_PIN},
      {8'hFF, 1'b0, 1'b0, NO_PIN},
      {8'hFF, 1'b0, 1'b0, NO_PIN},
      {8'hFF, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'd0}},
      // empty definite map -> rejected, no b
      {8'hA0, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'd0}}
   };

   cbor_block_message_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .push              (push),
      .full              (full),
      .empty             (empty),
      .pop               (pop),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_done_res      (rsp_done_res),
      .rsp_accepted      (rsp_accepted),
      .rsp_block_num     (rsp_block_num),
      .rsp_file_num      (rsp_file_num),
      .rsp_payload_count (rsp_payload_count)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder

   function automatic void clear_parser();
      parse_phase    = PH_MAP_HEAD;
      indef_map      = 1'b0;
      pairs_to_go    = '0;
      key_kind       = KEY_NONE;
      key_chars_left = '0;
      uint_acc       = '0;
      count_left     = '0;
      blk_val        = 32'hFFFF_FFFF;
      file_id        = '0;
      bstr_len       = '0;
      bstr_seen      = 1'b0;
   endfunction

   // Advance to the next key, or close a definite map after its last pair
   function automatic void close_pair();
      if (indef_map) begin
         parse_phase = PH_KEY_HEAD;
      end else begin
         pairs_to_go = pairs_to_go - 5'd1;
         parse_phase = (pairs_to_go == 0) ? PH_DONE : PH_KEY_HEAD;
      end
   endfunction

   function automatic void store_uint(input logic [31:0] v);
      case (key_kind)
         KEY_C:   blk_val = v;
         KEY_I:   file_id = v;
         default: ;
      endcase
      close_pair();
   endfunction

   function automatic void open_bstr(input logic [15:0] n);
      bstr_len  = n;
      bstr_seen = 1'b1;
      if (n == 0) begin
         close_pair();
      end else begin
         count_left  = n;
         parse_phase = PH_BSTR_DATA;
      end
   endfunction

   function automatic void route_key();
      if (key_kind == KEY_B)
         parse_phase = PH_BSTR_HEAD;
      else if (key_kind == KEY_C || key_kind == KEY_I || key_kind == KEY_L)
         parse_phase = PH_UINT_HEAD;
      else
         parse_phase = PH_FAIL;
   endfunction

   // Take one byte; return 1 with the result word when the byte yields one
   function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                      output rsp_type word);
      logic       pv;
      logic [7:0] pb;
      logic       verdict;
      pv      = 1'b0;
      pb      = 8'h00;
      verdict = 1'b0;
      word    = '0;

      case (parse_phase)
         PH_MAP_HEAD: begin
            if (b == MAP_INDEF) begin
               indef_map   = 1'b1;
               parse_phase = PH_KEY_HEAD;
            end else if (b >= MAP_DEF_LO && b <= MAP_DEF_HI) begin
               pairs_to_go = 5'(b - MAP_DEF_LO);
               parse_phase = (pairs_to_go == 0) ? PH_DONE : PH_KEY_HEAD;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_KEY_HEAD: begin
            if (indef_map && b == BREAK_CODE) begin
               parse_phase = PH_DONE;
            end else if (b >= TEXT_LO && b <= TEXT_HI &&
                         (b - TEXT_LO) < KEY_BUFFER_BYTES) begin
               key_chars_left = KEY_LEN_W'(b - TEXT_LO);
               if (key_chars_left == 0) begin
                  key_kind = KEY_OTHER;
                  route_key();
               end else begin
                  key_kind    = (key_chars_left == 1) ? KEY_PENDING : KEY_OTHER;
                  parse_phase = PH_KEY_TEXT;
               end
            end else begin
               parse_phase = indef_map ? PH_DONE : PH_FAIL;
            end
         end
         PH_KEY_TEXT: begin
            if (key_kind == KEY_PENDING)
               key_kind = (b == CHAR_C) ? KEY_C : (b == CHAR_I) ? KEY_I :
                          (b == CHAR_L) ? KEY_L : (b == CHAR_B) ? KEY_B : KEY_OTHER;
            key_chars_left = key_chars_left - KEY_LEN_W'(1);
            if (key_chars_left == 0)
               route_key();
         end
         PH_UINT_HEAD: begin
            uint_acc = '0;
            if (b <= UINT_IMM_MAX) begin
               store_uint({24'h0, b});
            end else if (b >= UINT_1B && b <= UINT_4B) begin
               count_left  = (b == UINT_1B) ? 16'd1 : (b == UINT_2B) ? 16'd2 : 16'd4;
               parse_phase = PH_UINT_BYTES;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_UINT_BYTES: begin
            uint_acc   = {uint_acc[23:0], b};
            count_left = count_left - 16'd1;
            if (count_left == 0)
               store_uint(uint_acc);
         end
         PH_BSTR_HEAD: begin
            uint_acc = '0;
            if (b >= BSTR_LO && b <= BSTR_HI) begin
               open_bstr({8'h00, b - BSTR_LO});
            end else if (b == BSTR_1B || b == BSTR_2B) begin
               count_left  = (b == BSTR_1B) ? 16'd1 : 16'd2;
               parse_phase = PH_BSTR_LEN;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_BSTR_LEN: begin
            uint_acc   = {16'h0, uint_acc[7:0], b};
            count_left = count_left - 16'd1;
            if (count_left == 0)
               open_bstr(uint_acc[15:0]);
         end
         PH_BSTR_DATA: begin
            pv         = 1'b1;
            pb         = b;
            count_left = count_left - 16'd1;
            if (count_left == 0)
               close_pair();
         end
         default: ;
      endcase

      if (!pv && !lst)
         return 1'b0;

      // Verdict on the last byte
      if (lst) begin
         if (parse_phase == PH_DONE)
            verdict = indef_map ? bstr_seen : (bstr_seen && !blk_val[31]);
         else if (indef_map && (parse_phase == PH_KEY_HEAD || parse_phase == PH_KEY_TEXT))
            verdict = bstr_seen;
      end
      word.payload_valid = pv;
      word.payload_byte  = pb;
      word.done_res      = lst;
      word.accepted      = verdict;
      word.block_num     = blk_val;
      word.file_num      = file_id;
      word.payload_count = bstr_len;
      if (lst)
         clear_parser();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------- scoreboard

   task automatic report_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // Predict on every input beat, check every result beat
   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type seen;
      bit      moved;
      moved = 1'b0;
      if (reset) begin
         clear_parser();
         rsp_due_q.delete();
         idle_cycles = 0;
      end else begin
         if (push && !full) begin
            moved = 1'b1;
            if (decode_byte(req_data_byte, req_last, predicted))
               rsp_due_q.push_back(pin_active ? pin_word : predicted);
         end
         if (pop && !empty) begin
            moved              = 1'b1;
            seen.payload_valid = rsp_payload_valid;
            seen.payload_byte  = rsp_payload_byte;
            seen.done_res      = rsp_done_res;
            seen.accepted      = rsp_accepted;
            seen.block_num     = rsp_block_num;
            seen.file_num      = rsp_file_num;
            seen.payload_count = rsp_payload_count;
            if (rsp_due_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, seen);
               mismatch_count++;
            end else begin
               predicted = rsp_due_q.pop_front();
               report_field("payload_valid", predicted.payload_valid, seen.payload_valid);
               report_field("payload_byte", predicted.payload_byte, seen.payload_byte);
               report_field("done_res", predicted.done_res, seen.done_res);
               report_field("accepted", predicted.accepted, seen.accepted);
               report_field("block_num", predicted.block_num, seen.block_num);
               report_field("file_num", predicted.file_num, seen.file_num);
               report_field("payload_count", predicted.payload_count, seen.payload_count);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // End the run if nothing moves for too long
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("[cbor_block_message_parser_core] ERROR");
      $finish;
   end

   // ------------------------------------------------------------- stimulus

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Random stretches of pop high and pop low
   initial begin : pop_pacer
      bit pop_on;
      int pop_left;
      pop_on   = 1'b0;
      pop_left = 0;
      forever begin
         @(negedge clock);
         if (pop_left == 0) begin
            if (pop_on)
               pop_left = pick_gap();
            if (pop_left == 0) begin
               pop_on   = 1'b1;
               pop_left = $urandom_range(1, 40);
            end else begin
               pop_on = 1'b0;
            end
         end
         pop <= pop_on;
         pop_left--;
      end
   end

   // Present one byte after an optional gap and hold it until taken
   task automatic feed_byte(input logic [7:0] b, input logic lst, input bit steady,
                            input bit pinned, input rsp_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push          <= 1'b1;
      req_data_byte <= b;
      req_last      <= lst;
      pin_active     = pinned;
      pin_word       = want;
      do @(posedge clock); while (full);
   endtask

   task automatic put_uint();
      logic [31:0]   v;
      head_form_type form;
      int            r;
      r = $urandom_range(0, 99);
      v = (r < 40) ? 32'($urandom_range(0, 65535)) : (r < 55) ? 32'h0 :
          (r < 65) ? 32'hFFFF_FFFF : (r < 72) ? 32'h7FFF_FFFF :
          (r < 78) ? 32'h8000_0000 : $urandom;
      form = ($urandom_range(0, 19) == 0) ? UF_BAD : head_form_type'($urandom_range(0, 3));
      case (form)
         UF_IMM:  msg_bytes.push_back(8'(v % 24));
         UF_ONE: begin
            msg_bytes.push_back(UINT_1B);
            msg_bytes.push_back(v[7:0]);
         end
         UF_TWO: begin
            msg_bytes.push_back(UINT_2B);
            msg_bytes.push_back(v[15:8]);
            msg_bytes.push_back(v[7:0]);
         end
         UF_FOUR: begin
            msg_bytes.push_back(UINT_4B);
            msg_bytes.push_back(v[31:24]);
            msg_bytes.push_back(v[23:16]);
            msg_bytes.push_back(v[15:8]);
            msg_bytes.push_back(v[7:0]);
         end
         default: msg_bytes.push_back(8'($urandom_range(UINT_4B + 1, 255)));
      endcase
   endtask

   // KEY_OTHER: random text key of legal length; KEY_NONE: bad key head
   task automatic put_key(input key_type k);
      int         n;
      logic [7:0] h;
      case (k)
         KEY_C, KEY_I, KEY_L, KEY_B: begin
            msg_bytes.push_back(TEXT_LO + 8'd1);
            msg_bytes.push_back((k == KEY_C) ? CHAR_C : (k == KEY_I) ? CHAR_I :
                                (k == KEY_L) ? CHAR_L : CHAR_B);
         end
         KEY_OTHER: begin
            n = $urandom_range(0, KEY_BUFFER_BYTES - 1);
            msg_bytes.push_back(TEXT_LO + 8'(n));
            repeat (n)
               msg_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(CHAR_B, CHAR_L))
                                                        : 8'($urandom));
         end
         default: begin
            do h = 8'($urandom);
            while (h >= TEXT_LO && h < TEXT_LO + KEY_BUFFER_BYTES);
            msg_bytes.push_back(h);
         end
      endcase
   endtask

   // Byte string value; returns 1 when the message is cut off inside it
   task automatic put_bstr(output bit cut);
      int            r;
      int            len;
      logic [7:0]    h;
      head_form_type form;
      cut = 1'b0;
      r   = $urandom_range(0, 99);
      if (r < 3) begin
         // maximum declared length, far more than is sent
         msg_bytes.push_back(BSTR_2B);
         msg_bytes.push_back(8'hFF);
         msg_bytes.push_back(8'hFF);
         repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
         cut = 1'b1;
      end else if (r < 7) begin
         do h = 8'($urandom);
         while (h >= BSTR_LO && h <= BSTR_2B);
         msg_bytes.push_back(h);
      end else begin
         len  = (r < 75) ? $urandom_range(0, 8) : (r < 96) ? $urandom_range(9, 40)
                                                           : $urandom_range(41, 300);
         form = (len < 24)  ? head_form_type'($urandom_range(UF_IMM, UF_TWO)) :
                (len < 256) ? head_form_type'($urandom_range(UF_ONE, UF_TWO)) : UF_TWO;
         case (form)
            UF_IMM: msg_bytes.push_back(BSTR_LO + 8'(len));
            UF_ONE: begin
               msg_bytes.push_back(BSTR_1B);
               msg_bytes.push_back(8'(len));
            end
            default: begin
               msg_bytes.push_back(BSTR_2B);
               msg_bytes.push_back(8'(len >> 8));
               msg_bytes.push_back(8'(len));
            end
         endcase
         repeat (len) msg_bytes.push_back(8'($urandom));
      end
   endtask

   // Build one message: mostly well-formed maps, some broken or noise
   task automatic compose_message();
      int      r;
      int      npairs;
      bit      indef;
      bit      cut;
      key_type k;
      msg_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
      end else begin
         indef  = ($urandom_range(0, 2) == 0);
         npairs = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 23) : $urandom_range(1, 4);
         msg_bytes.push_back(indef ? MAP_INDEF : MAP_DEF_LO + 8'(npairs));
         cut = 1'b0;
         for (int i = 0; i < npairs && !cut; i++) begin
            r = $urandom_range(0, 99);
            k = (r < 30) ? KEY_B : (r < 55) ? KEY_C : (r < 68) ? KEY_I :
                (r < 78) ? KEY_L : (r < 94) ? KEY_OTHER : KEY_NONE;
            put_key(k);
            if (k == KEY_B)
               put_bstr(cut);
            else if (k != KEY_NONE)
               put_uint();
         end
         if (indef && !cut && $urandom_range(0, 4) != 0)
            msg_bytes.push_back(BREAK_CODE);

         // Truncate, corrupt or pad some messages
         r = $urandom_range(0, 99);
         if (r < 10) begin
            npairs = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > npairs) void'(msg_bytes.pop_back());
         end else if (r < 18) begin
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
         end else if (r < 26) begin
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      int bytes_fed;
      bit steady;
      bytes_fed = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scripted messages
      foreach (opening_script[i])
         feed_byte(opening_script[i].data, opening_script[i].is_last, 1'b0,
                   opening_script[i].pinned, opening_script[i].want);

      // Random messages, some sent back to back
      while (bytes_fed < RANDOM_BYTES) begin
         compose_message();
         steady = ($urandom_range(0, 3) == 0);
         foreach (msg_bytes[i])
            feed_byte(msg_bytes[i], i == msg_bytes.size() - 1, steady, 1'b0, NO_PIN);
         bytes_fed += msg_bytes.size();
      end
      @(negedge clock);
      push <= 1'b0;

      // Drain and let any stray result show up
      while (rsp_due_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[cbor_block_message_parser_core] OK");
      else
         $display("[cbor_block_message_parser_core] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hdl/cbp_pkg.sv
hdl/cbp_front.sv
hdl/cbp_back.sv
hdl/cbp_rsp_queue.sv
hdl/cbor_block_message_parser_core.sv
tb/sv/cbor_block_message_parser_core_tb.sv
